// ===== hdl/mrcs_pkg.sv =====
// ----------------------------------------------------------------------------
// mrcs_pkg
// Shared types and constants of the mesh region cluster set block.
// ----------------------------------------------------------------------------
`default_nettype none

package mrcs_pkg;

  localparam int MAX_GRID_SIDE_DEF = 8;
  localparam int MAX_CLUSTERS_DEF  = 16;

  localparam int CMD_W      = 2;
  localparam int IDX_W      = 6;
  localparam int VAL_W      = 6;
  localparam int CORE_W     = 6;
  localparam int RAD_W      = 4;
  localparam int MASK_W     = 16;
  localparam int TOTAL_W    = 5;
  localparam int STATUS_W   = 2;
  localparam int GRID_REG_W = 4;
  localparam int CLU_REG_W  = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [GRID_REG_W-1:0] GRID_W_RST   = 4'd8;
  localparam logic [GRID_REG_W-1:0] GRID_H_RST   = 4'd8;
  localparam logic [CLU_REG_W-1:0]  CLUSTERS_RST = 5'd16;

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_OWNER,
    CMD_WR_HEAD,
    CMD_QUERY
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_UNMATCHED,
    ST_OUTSIDE
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH,
    REG_GRID_HEIGHT,
    REG_CLUSTERS
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOCATE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [IDX_W-1:0]  entry_index;
    logic [VAL_W-1:0]  entry_value;
    logic [CORE_W-1:0] center_core;
    logic [RAD_W-1:0]  radius;
  } in_word_t;

  typedef struct packed {
    logic [MASK_W-1:0]   cluster_mask;
    logic [TOTAL_W-1:0]  cluster_total;
    logic [STATUS_W-1:0] status;
  } out_word_t;

endpackage

`default_nettype wire

// ===== hdl/mesh_region_cluster_set.sv =====
// ----------------------------------------------------------------------------
// mesh_region_cluster_set
// Owner table in a synchronous RAM, head table in flops; region scan over the
// mesh one core per cycle with a parallel head search.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (in_valid / in_stall) carry a command. Owner and head writes
//   are taken and give no result; the next word may follow at once. A query
//   steps row by row through the locate state to find the center row, then
//   scans the grid one core per cycle through the owner RAM read port, passes
//   a drain state and loads the output register in the done state; then the
//   block returns to idle and takes the next word. The RAM port, one read per
//   cycle, sets the length of the scan. A center outside the grid goes from
//   the locate state straight to the done state and returns status 2.
//   Results (out_valid / out_stall) sit in an output register; the block takes
//   new words while a result waits, but a finished query holds until the
//   output register is free. While busy with a query, in_stall is high.
//   Reset (rst_n low, synchronous) sets the registers to 8 x 8 grid and 16
//   clusters and drops all valids; the tables are undefined until written.
//   Configuration (cfg_we / cfg_index / cfg_data) is to be written while idle
//   only; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module mesh_region_cluster_set #(
  parameter int MAX_GRID_SIDE = mrcs_pkg::MAX_GRID_SIDE_DEF,
  parameter int MAX_CLUSTERS  = mrcs_pkg::MAX_CLUSTERS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [mrcs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mrcs_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  mrcs_pkg::in_word_t                in_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output mrcs_pkg::out_word_t               out_word
);
  import mrcs_pkg::*;

  localparam int CORE_SLOTS = MAX_GRID_SIDE * MAX_GRID_SIDE;
  localparam int AW   = $clog2(CORE_SLOTS);
  localparam int SW   = $clog2(MAX_GRID_SIDE + 1);
  localparam int LW   = ((2 * SW > CORE_W) ? 2 * SW : CORE_W) + 1;
  localparam int DW   = (SW + 1 > RAD_W) ? SW + 1 : RAD_W;
  localparam int KW   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int NCW  = $clog2(MAX_CLUSTERS + 1);
  localparam int GCW  = (SW > GRID_REG_W) ? SW : GRID_REG_W;
  localparam int CLW  = (NCW > CLU_REG_W) ? NCW : CLU_REG_W;
  localparam int HCW  = (IDX_W > NCW) ? IDX_W + 1 : NCW + 1;
  localparam int MXW  = MASK_W + MAX_CLUSTERS;
  localparam int TXW  = TOTAL_W + NCW;

  // configuration
  logic [GRID_REG_W-1:0] grid_w_r, grid_h_r;
  logic [CLU_REG_W-1:0]  clusters_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_w_r   <= GRID_W_RST;
      grid_h_r   <= GRID_H_RST;
      clusters_r <= CLUSTERS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_WIDTH:  grid_w_r   <= cfg_data[GRID_REG_W-1:0];
        REG_GRID_HEIGHT: grid_h_r   <= cfg_data[GRID_REG_W-1:0];
        REG_CLUSTERS:    clusters_r <= cfg_data[CLU_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // saturated sizes
  logic [GCW-1:0] gw_ext, gh_ext;
  logic [CLW-1:0] nc_ext;
  logic [SW-1:0]  w_c, h_c;
  logic [NCW-1:0] nc_c;
  logic [LW-1:0]  area;

  always_comb begin
    gw_ext = GCW'(grid_w_r);
    gh_ext = GCW'(grid_h_r);
    nc_ext = CLW'(clusters_r);
    if (gw_ext == '0)                       w_c = SW'(1);
    else if (gw_ext > GCW'(MAX_GRID_SIDE))  w_c = SW'(MAX_GRID_SIDE);
    else                                    w_c = SW'(gw_ext);
    if (gh_ext == '0)                       h_c = SW'(1);
    else if (gh_ext > GCW'(MAX_GRID_SIDE))  h_c = SW'(MAX_GRID_SIDE);
    else                                    h_c = SW'(gh_ext);
    if (nc_ext == '0)                       nc_c = NCW'(1);
    else if (nc_ext > CLW'(MAX_CLUSTERS))   nc_c = NCW'(MAX_CLUSTERS);
    else                                    nc_c = NCW'(nc_ext);
    area = LW'(w_c) * LW'(h_c);
  end

  // state
  state_t                state_r, state_nxt;
  logic [CORE_W-1:0]     center_r, center_nxt;
  logic [RAD_W-1:0]      radius_r, radius_nxt;
  logic [LW-1:0]         base_r, base_nxt;
  logic [SW-1:0]         cx_r, cx_nxt, cy_r, cy_nxt;
  logic [SW-1:0]         x_r, x_nxt, y_r, y_nxt;
  logic [AW-1:0]         addr_r, addr_nxt;
  logic                  vis_r, vis_nxt;
  logic [MAX_CLUSTERS-1:0] mask_r, mask_nxt;
  logic [NCW-1:0]        total_r, total_nxt;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_word_t             out_word_r, out_word_nxt;

  // tables
  logic [VAL_W-1:0] owner_mem [CORE_SLOTS];
  logic [VAL_W-1:0] head_r    [MAX_CLUSTERS];
  logic [VAL_W-1:0] rd_data_r;
  logic             owner_we, head_we;

  always_ff @(posedge clk) begin
    if (owner_we) begin
      owner_mem[AW'(in_word.entry_index)] <= in_word.entry_value;
    end
    rd_data_r <= owner_mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_r[KW'(in_word.entry_index)] <= in_word.entry_value;
    end
  end

  // head search on the word just read, lowest index wins
  logic          hit_any;
  logic [KW-1:0] hit_idx;

  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int k = MAX_CLUSTERS - 1; k >= 0; k--) begin
      if (NCW'(k) < nc_c && head_r[k] == rd_data_r) begin
        hit_any = 1'b1;
        hit_idx = KW'(k);
      end
    end
  end

  // region test for the core being read
  logic [SW-1:0] dx, dy;
  logic [DW-1:0] hops;
  logic          in_region, x_last, y_last;
  logic [LW-1:0] center_ext, cx_diff;
  logic [MXW-1:0] mask_ext;
  logic [TXW-1:0] total_ext;

  always_comb begin
    dx        = (x_r >= cx_r) ? x_r - cx_r : cx_r - x_r;
    dy        = (y_r >= cy_r) ? y_r - cy_r : cy_r - y_r;
    hops      = DW'(dx) + DW'(dy);
    in_region = hops <= DW'(radius_r);
    x_last    = x_r == w_c - SW'(1);
    y_last    = y_r == h_c - SW'(1);
    center_ext = LW'(center_r);
    cx_diff    = center_ext - base_r;
    mask_ext   = MXW'(mask_r);
    total_ext  = TXW'(total_r);
  end

  logic in_acc, out_acc;

  always_comb begin
    state_nxt     = state_r;
    center_nxt    = center_r;
    radius_nxt    = radius_r;
    base_nxt      = base_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    addr_nxt      = addr_r;
    vis_nxt       = 1'b0;
    mask_nxt      = mask_r;
    total_nxt     = total_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    owner_we      = 1'b0;
    head_we       = 1'b0;

    in_stall = state_r != S_IDLE;
    in_acc   = in_valid && !in_stall;
    out_acc  = out_valid_r && !out_stall;

    if (out_acc) out_valid_nxt = 1'b0;

    // fold in the owner word read in the previous cycle
    if (vis_r) begin
      if (!hit_any) begin
        status_nxt = ST_UNMATCHED;
      end else if (!mask_r[hit_idx]) begin
        mask_nxt[hit_idx] = 1'b1;
        total_nxt         = total_r + NCW'(1);
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_word.command)
            CMD_WR_OWNER: begin
              owner_we = LW'(in_word.entry_index) < LW'(CORE_SLOTS);
            end
            CMD_WR_HEAD: begin
              head_we = HCW'(in_word.entry_index) < HCW'(MAX_CLUSTERS);
            end
            CMD_QUERY: begin
              center_nxt = in_word.center_core;
              radius_nxt = in_word.radius;
              base_nxt   = '0;
              cy_nxt     = '0;
              mask_nxt   = '0;
              total_nxt  = '0;
              status_nxt = ST_OK;
              state_nxt  = S_LOCATE;
            end
            default: ;
          endcase
        end
      end
      S_LOCATE: begin
        // find the center row by stepping one row of cores per cycle
        if (center_ext >= area) begin
          status_nxt = ST_OUTSIDE;
          state_nxt  = S_DONE;
        end else if (center_ext < base_r + LW'(w_c)) begin
          cx_nxt    = cx_diff[SW-1:0];
          x_nxt     = '0;
          y_nxt     = '0;
          addr_nxt  = '0;
          state_nxt = S_SCAN;
        end else begin
          base_nxt = base_r + LW'(w_c);
          cy_nxt   = cy_r + SW'(1);
        end
      end
      S_SCAN: begin
        vis_nxt  = in_region;
        addr_nxt = addr_r + AW'(1);
        if (x_last) begin
          x_nxt = '0;
          y_nxt = y_r + SW'(1);
          if (y_last) state_nxt = S_DRAIN;
        end else begin
          x_nxt = x_r + SW'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_acc) begin
          out_valid_nxt              = 1'b1;
          out_word_nxt.cluster_mask  = mask_ext[MASK_W-1:0];
          out_word_nxt.cluster_total = total_ext[TOTAL_W-1:0];
          out_word_nxt.status        = status_r;
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vis_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vis_r       <= vis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    center_r   <= center_nxt;
    radius_r   <= radius_nxt;
    base_r     <= base_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    addr_r     <= addr_nxt;
    mask_r     <= mask_nxt;
    total_r    <= total_nxt;
    status_r   <= status_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // checks
  a_total_matches_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (MAX_CLUSTERS > MASK_W ||
                     $countones(out_word_r.cluster_mask) == out_word_r.cluster_total))
    else $error("cluster_total does not match cluster_mask");

  a_outside_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.status == ST_OUTSIDE) |->
      (out_word_r.cluster_mask == '0 && out_word_r.cluster_total == '0))
    else $error("outside-grid result carries clusters");

  a_vis_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    vis_r |-> $past(state_r) == S_SCAN)
    else $error("region hit outside of scan");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result word loaded outside of done state");

endmodule

`default_nettype wire
